// ===== sv/sv39w_pkg.sv =====
package sv39w_pkg;

  localparam int unsigned TABLE_PAGES_DEF = 16;
  localparam int unsigned ENTRIES = 512;
  localparam int unsigned IDX_W = 9;
  localparam int unsigned PPN_W = 44;
  localparam int unsigned VA_W = 39;
  localparam int unsigned PA_W = 56;
  localparam int unsigned FLAG_W = 10;
  localparam int unsigned LIMIT_W = 40;
  localparam int unsigned ENTRY_W = 54;
  localparam int unsigned CFG_W = 44;

  localparam logic [PPN_W-1:0] BASE_RST = 44'd524288;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 40'd274877906944;

  // config register indexes
  localparam logic CFG_TABLE_BASE = 1'b0;
  localparam logic CFG_VA_LIMIT = 1'b1;

  // result status codes
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_RANGE = 3'd1;
  localparam logic [2:0] ST_ALIGN = 3'd2;
  localparam logic [2:0] ST_REMAP = 3'd3;
  localparam logic [2:0] ST_NOPAGE = 3'd4;
  localparam logic [2:0] ST_NOTMAP = 3'd5;

  // request types
  localparam logic REQ_MAP = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // walk levels
  localparam logic [1:0] LVL_0 = 2'd0;
  localparam logic [1:0] LVL_1 = 2'd1;
  localparam logic [1:0] LVL_2 = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [VA_W-1:0]   virt_addr;
    logic [PA_W-1:0]   phys_addr;
    logic [FLAG_W-1:0] perm_flags;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [ENTRY_W-1:0] leaf_entry;
  } rsp_t;

  typedef struct packed {
    logic       clear;
    logic       accept;
    logic       walk;
    logic [1:0] level;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic req_err;
    logic walk_stop;
  } ctrl_sts_t;

endpackage

// ===== sv/sv39w_ram.sv =====
module sv39w_ram #(
  parameter int unsigned WIDTH = 54,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sv39w_ctrl.sv =====
module sv39w_ctrl
  import sv39w_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  ctrl_sts_t  sts_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_L2    = 3'd2;
  localparam logic [2:0] S_L1    = 3'd3;
  localparam logic [2:0] S_L0    = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.level  = LVL_0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = sts_i.req_err ? S_RESP : S_L2;
        end
      end
      S_L2: begin
        cmd_o.walk  = 1'b1;
        cmd_o.level = LVL_2;
        state_d = sts_i.walk_stop ? S_RESP : S_L1;
      end
      S_L1: begin
        cmd_o.walk  = 1'b1;
        cmd_o.level = LVL_1;
        state_d = sts_i.walk_stop ? S_RESP : S_L0;
      end
      S_L0: begin
        cmd_o.walk  = 1'b1;
        cmd_o.level = LVL_0;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_l0_to_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_L0) |=> (state_q == S_RESP))
    else $error("leaf level did not hand over to response");

  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && !out_free) |=> (state_q == S_RESP && out_valid_q))
    else $error("response dropped while output busy");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |-> (!cmd_o.walk && !cmd_o.clear))
    else $error("accept overlaps a walk or clear");

endmodule

// ===== sv/sv39w_dp.sv =====
module sv39w_dp
  import sv39w_pkg::*;
#(
  parameter int unsigned TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  req_t              in_data_i,
  output rsp_t              out_data_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  ctrl_cmd_t         cmd_i,
  output ctrl_sts_t         sts_o
);

  localparam int unsigned DEPTH = TABLE_PAGES * ENTRIES;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PGW = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int unsigned NFW = $clog2(TABLE_PAGES + 1);

  logic [PPN_W-1:0]   base_q;
  logic [LIMIT_W-1:0] limit_q;

  logic               lookup_q;
  logic [26:0]        vpn_q;
  logic [PPN_W-1:0]   ppn_q;
  logic [FLAG_W-1:0]  perm_q;
  logic [PGW-1:0]     page_q, page_d;
  logic [AW-1:0]      slot_q;
  logic [NFW-1:0]     nfree_q, nfree_d;
  logic [AW-1:0]      clr_q;
  logic [2:0]         status_q, status_d;
  logic [ENTRY_W-1:0] leaf_q, leaf_d;
  rsp_t               out_q;

  logic               walk_we;
  logic [ENTRY_W-1:0] walk_wdata;
  logic [PGW+IDX_W-1:0] raddr_full;
  logic [IDX_W-1:0]   ridx;
  logic [AW-1:0]      raddr;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] rdata;

  logic               pte_v;
  logic [PPN_W-1:0]   rel;
  logic               hit;
  logic [PPN_W-1:0]   alloc_ppn;
  logic               err_align, err_range;
  logic               stop;
  logic [2:0]         stop_code;

  assign pte_v     = rdata[0];
  assign rel       = rdata[ENTRY_W-1:FLAG_W] - base_q;
  assign hit       = rel < PPN_W'(nfree_q);
  assign alloc_ppn = base_q + PPN_W'(nfree_q);

  assign err_align = (in_data_i.req_type == REQ_MAP) &&
                     ((in_data_i.virt_addr[11:0] | in_data_i.phys_addr[11:0]) != 12'd0);
  assign err_range = {1'b0, in_data_i.virt_addr} >= limit_q;

  always_comb begin
    page_d     = page_q;
    nfree_d    = nfree_q;
    status_d   = status_q;
    leaf_d     = leaf_q;
    walk_we    = 1'b0;
    walk_wdata = '0;
    stop       = 1'b0;
    stop_code  = ST_OK;
    ridx       = in_data_i.virt_addr[38:30];

    if (cmd_i.accept) begin
      page_d   = '0;
      leaf_d   = '0;
      status_d = err_align ? ST_ALIGN : (err_range ? ST_RANGE : ST_OK);
    end else if (cmd_i.walk) begin
      case (cmd_i.level)
        LVL_2, LVL_1: begin
          ridx = (cmd_i.level == LVL_2) ? vpn_q[17:9] : vpn_q[8:0];
          if (pte_v) begin
            if (hit) begin
              page_d = rel[PGW-1:0];
            end else begin
              stop = 1'b1;
              stop_code = lookup_q ? ST_NOTMAP : ST_NOPAGE;
            end
          end else if (lookup_q) begin
            stop = 1'b1;
            stop_code = ST_NOTMAP;
          end else if (nfree_q == NFW'(TABLE_PAGES)) begin
            stop = 1'b1;
            stop_code = ST_NOPAGE;
          end else begin
            // fresh page is already zero from the reset sweep
            walk_we    = 1'b1;
            walk_wdata = {alloc_ppn, {(FLAG_W-1){1'b0}}, 1'b1};
            page_d     = nfree_q[PGW-1:0];
            nfree_d    = nfree_q + NFW'(1);
          end
          if (stop) begin
            status_d = stop_code;
            leaf_d   = '0;
          end
        end
        LVL_0: begin
          if (lookup_q) begin
            status_d = pte_v ? ST_OK : ST_NOTMAP;
            leaf_d   = pte_v ? rdata : '0;
          end else if (pte_v) begin
            status_d = ST_REMAP;
            leaf_d   = '0;
          end else begin
            walk_we    = 1'b1;
            walk_wdata = {ppn_q, perm_q | FLAG_W'(1)};
            status_d   = ST_OK;
            leaf_d     = {ppn_q, perm_q | FLAG_W'(1)};
          end
        end
        default: begin
          stop = 1'b1;
        end
      endcase
    end
  end

  assign raddr_full = {page_d, ridx};
  assign raddr      = raddr_full[AW-1:0];

  assign mem_we    = cmd_i.clear || walk_we;
  assign mem_waddr = cmd_i.clear ? clr_q : slot_q;
  assign mem_wdata = cmd_i.clear ? '0 : walk_wdata;

  sv39w_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BASE_RST;
      limit_q <= LIMIT_RST;
      nfree_q <= NFW'(1);
      clr_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TABLE_BASE: base_q  <= cfg_data_i;
          CFG_VA_LIMIT:   limit_q <= cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
      nfree_q <= nfree_d;
      if (cmd_i.clear) clr_q <= clr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      lookup_q <= in_data_i.req_type;
      vpn_q    <= in_data_i.virt_addr[38:12];
      ppn_q    <= in_data_i.phys_addr[55:12];
      perm_q   <= in_data_i.perm_flags;
    end
    if (cmd_i.accept || cmd_i.walk) begin
      page_q   <= page_d;
      slot_q   <= raddr;
      status_q <= status_d;
      leaf_q   <= leaf_d;
    end
    if (cmd_i.out_load) begin
      out_q.status     <= status_q;
      out_q.leaf_entry <= leaf_q;
    end
  end

  assign out_data_o       = out_q;
  assign sts_o.clear_last = (clr_q == AW'(DEPTH - 1));
  assign sts_o.req_err    = err_align || err_range;
  assign sts_o.walk_stop  = stop;

  a_nfree_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nfree_q != '0) && (nfree_q <= NFW'(TABLE_PAGES)))
    else $error("free page pointer out of bounds");

  a_write_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_we |-> (NFW'(page_q) < nfree_q))
    else $error("walk writes into an unallocated page");

endmodule

// ===== sv/sv39_page_table_map_walk_unit.sv =====
// Sv39 page table map / walk unit.
// Holds a three-level page table in a private store of TABLE_PAGES pages
// (512 entries each, page 0 is the root, further pages handed out in order).
// Input channel (in_valid_i/in_ready_o/in_data_i): one beat per request, map
// (allocating intermediate tables, writing the leaf) or lookup.
// Output channel (out_valid_o/out_ready_i/out_data_o): one beat per request
// with status and leaf entry; leaf is zero on any error.
// Config port: cfg_we_i writes cfg_idx_i (0 table base PPN, 1 VA limit) in
// the same cycle; write only while no request is in flight.
// Sequence: a request that fails the alignment/range check goes from accept
// straight to the response state. A full walk runs accept, one state per
// level L2/L1/L0, response; a walk may also stop at L2 or at L1 and go to the
// response from there. The single table RAM port pair sets this: each level
// needs the registered read of the previous level before it can go on.
// Reset: a clearing sweep zeroes all TABLE_PAGES*512 entries of the store
// (8192 at the default); no request is taken during it.
// Stall: the result sits in an output register; a new request is taken
// while it waits, but the next result holds in the response state until
// the output register frees up.
module sv39_page_table_map_walk_unit
  import sv39w_pkg::*;
#(
  parameter int unsigned TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  req_t             in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rsp_t             out_data_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  // command / status between controller and datapath
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  sv39w_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: config regs, request regs, free page pointer, table RAM
  sv39w_dp #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

// ===== dv/sv39_page_table_map_walk_unit_tb.sv =====
`timescale 1ns / 1ps

module sv39_page_table_map_walk_unit_tb;
  import sv39w_pkg::*;

  localparam int unsigned TBL_PAGES   = TABLE_PAGES_DEF;
  localparam int unsigned TBL_ENTRIES = TBL_PAGES * ENTRIES;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam int unsigned NUM_PHASES  = 8;
  // Reset runs a clearing sweep over the whole store before the first beat,
  // so the quiet-cycle limit has to clear that with plenty of room.
  localparam int unsigned WDOG_LIMIT  = 3 * TBL_ENTRIES + 2000;
  localparam logic [PPN_W-1:0]   DIR_BASE = 44'hFFF_FFFF_FFFE;  // pages wrap past 2^44
  localparam logic [LIMIT_W-1:0] VA_TOP   = 40'h80_0000_0000;   // whole 39-bit space

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  req_t             in_data_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  rsp_t             out_data_o;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = CFG_TABLE_BASE;
  logic [CFG_W-1:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  sv39_page_table_map_walk_unit #(
    .TABLE_PAGES(TBL_PAGES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Shadow page table: own copy of the store, the bump pointer and the regs.
  // --------------------------------------------------------------------------
  logic [63:0]        tbl_mem [TBL_ENTRIES];
  int unsigned        next_pg;
  logic [PPN_W-1:0]   base_ppn;
  logic [LIMIT_W-1:0] va_lim;

  req_t               req_q[$];       // requests waiting to be driven
  rsp_t               walk_rsp_q[$];  // predicted walk results, oldest first
  logic [VA_W-1:0]    va_pool[$];     // addresses already sent as maps
  int unsigned        send_idle_pct = 0;
  int unsigned        stall_pct = 0;
  int unsigned        err_cnt = 0;
  int unsigned        n_req = 0;
  int unsigned        n_settings = 0;
  int unsigned        quiet_cycles = 0;
  int unsigned        status_seen [8];
  rsp_t               want_rsp;

  // Walk one request through the shadow table, updating it like a map would.
  function automatic rsp_t predict_walk(input req_t r);
    logic               lookup;
    logic [2:0]         st;
    logic [ENTRY_W-1:0] leaf;
    logic [63:0]        pte;
    logic [PPN_W-1:0]   rel;
    logic [PPN_W-1:0]   ppn;
    int unsigned        pg;
    int unsigned        slot;
    int unsigned        np;
    int                 lvl;
    int                 k;
    rsp_t               rsp;
    lookup = (r.req_type == REQ_LOOKUP);
    st     = ST_OK;
    leaf   = '0;
    pg     = 0;
    // alignment beats the range check, and lookups skip the alignment check entirely
    if (!lookup && ((r.virt_addr[11:0] | r.phys_addr[11:0]) != 12'd0)) begin
      st = ST_ALIGN;
    end else if ({1'b0, r.virt_addr} >= va_lim) begin
      st = ST_RANGE;
    end else begin
      for (lvl = 2; lvl > 0; lvl--) begin
        if (st == ST_OK) begin
          slot = pg * ENTRIES + 32'(r.virt_addr[12 + IDX_W * lvl +: IDX_W]);
          pte  = tbl_mem[slot];
          if (pte[0]) begin
            // pointer must land on a handed-out page, relative to the base
            rel = pte[53:10] - base_ppn;
            if (rel >= PPN_W'(next_pg)) begin
              st = lookup ? ST_NOTMAP : ST_NOPAGE;
            end else begin
              pg = 32'(rel);
            end
          end else if (lookup) begin
            st = ST_NOTMAP;
          end else if (next_pg >= TBL_PAGES) begin
            st = ST_NOPAGE;
          end else begin
            np      = next_pg;
            next_pg = next_pg + 1;
            for (k = 0; k < ENTRIES; k++) tbl_mem[np * ENTRIES + k] = '0;
            ppn           = base_ppn + PPN_W'(np);
            tbl_mem[slot] = {10'd0, ppn, 10'd1};
            pg            = np;
          end
        end
      end
      if (st == ST_OK) begin
        slot = pg * ENTRIES + 32'(r.virt_addr[12 +: IDX_W]);
        pte  = tbl_mem[slot];
        if (lookup) begin
          if (pte[0]) leaf = pte[ENTRY_W-1:0];
          else st = ST_NOTMAP;
        end else if (pte[0]) begin
          st = ST_REMAP;
        end else begin
          leaf          = {r.phys_addr[PA_W-1:12], r.perm_flags | 10'd1};
          tbl_mem[slot] = {10'd0, leaf};
        end
      end
    end
    if (st != ST_OK) leaf = '0;
    rsp.status     = st;
    rsp.leaf_entry = leaf;
    return rsp;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: pops the pending queue, holds valid until the beat.
  // Prediction happens at the accepting edge so it sees the table in order.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        walk_rsp_q.push_back(predict_walk(in_data_i));
        n_req++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= req_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: random backpressure, field-by-field compare per beat.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (walk_rsp_q.size() == 0) begin
          $error("result beat with nothing pending: status %0d leaf_entry %h",
                 out_data_o.status, out_data_o.leaf_entry);
          err_cnt++;
        end else begin
          want_rsp = walk_rsp_q.pop_front();
          status_seen[want_rsp.status]++;
          if (out_data_o.status !== want_rsp.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   want_rsp.status, out_data_o.status);
            err_cnt++;
          end
          if (out_data_o.leaf_entry !== want_rsp.leaf_entry) begin
            $error("leaf_entry mismatch: expected %h, actual %h",
                   want_rsp.leaf_entry, out_data_o.leaf_entry);
            err_cnt++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: any beat on either channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("timeout: no beat for %0d cycles, %0d results outstanding",
                 quiet_cycles, walk_rsp_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Config write; only called with nothing in flight.
  task automatic write_cfg(input logic idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TABLE_BASE) base_ppn = val[PPN_W-1:0];
    else va_lim = val[LIMIT_W-1:0];
  endtask

  task automatic push_item(input logic kind, input logic [VA_W-1:0] va,
                           input logic [PA_W-1:0] pa, input logic [FLAG_W-1:0] perm);
    req_t r;
    r.req_type   = kind;
    r.virt_addr  = va;
    r.phys_addr  = pa;
    r.perm_flags = perm;
    req_q.push_back(r);
    if (kind == REQ_MAP) begin
      va_pool.push_back(va);
      if (va_pool.size() > 256) void'(va_pool.pop_front());
    end
  endtask

  // Sampled on the falling edge so queue updates at the rising edge are settled.
  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid_i || walk_rsp_q.size() != 0) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    int              phase;
    int              n;
    int              k;
    int              pick;
    logic [63:0]     rnd;
    logic [63:0]     base_v;
    logic [63:0]     lim_v;
    logic [8:0]      vpn2;
    logic [8:0]      vpn1;
    logic [VA_W-1:0] va;
    logic [PA_W-1:0] pa;

    for (k = 0; k < TBL_ENTRIES; k++) tbl_mem[k] = '0;
    for (k = 0; k < 8; k++) status_seen[k] = 0;
    next_pg  = 1;
    base_ppn = BASE_RST;
    va_lim   = LIMIT_RST;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Base just under 2^44 so the handed-out page numbers wrap through zero.
    write_cfg(CFG_TABLE_BASE, CFG_W'(DIR_BASE));
    n_settings++;

    // ---- directed: limit at reset value (2^38) ----
    push_item(REQ_LOOKUP, '0, '0, '0);                        // empty root
    push_item(REQ_MAP, '0, '0, '0);                           // allocates L1 + L0
    push_item(REQ_LOOKUP, '0, '1, '1);                        // pa/perm ignored
    push_item(REQ_MAP, '0, 56'h1000, 10'h3FF);                // remap
    push_item(REQ_MAP, 39'h1, 56'h5000, 10'h0);               // va misaligned
    push_item(REQ_MAP, 39'h3000, 56'h801, 10'h0);             // pa misaligned
    push_item(REQ_MAP, 39'h40_0000_0000, 56'h2000, 10'h0);    // va at limit
    push_item(REQ_LOOKUP, 39'h40_0000_0000, '0, '0);          // lookup out of range
    push_item(REQ_MAP, 39'h7F_FFFF_FFFF, 56'h1, 10'h0);       // align wins over range
    push_item(REQ_LOOKUP, 39'hFFF, '0, '0);                   // unaligned lookup hit
    push_item(REQ_MAP, 39'h3F_FFFF_F000, 56'hFF_FFFF_FFFF_F000, 10'h3FE);
    push_item(REQ_LOOKUP, 39'h3F_FFFF_FFFF, '0, '0);          // top of range, hit
    push_item(REQ_LOOKUP, 39'h1000, '0, '0);                  // invalid leaf
    push_item(REQ_LOOKUP, 39'h20_0000, '0, '0);               // missing L1 entry
    // burn pages: each new top-level slot costs two
    for (k = 1; k <= 5; k++) begin
      vpn2 = 9'(k);
      push_item(REQ_MAP, {vpn2, 30'd0}, PA_W'({$urandom, 12'h000}), 10'($urandom));
    end
    push_item(REQ_MAP, {9'd6, 30'd0}, 56'h7000, 10'h0);       // L1 ok, L0 out of pages
    push_item(REQ_MAP, {9'd6, 30'h1000}, 56'h8000, 10'h0);    // partial table kept, full
    push_item(REQ_LOOKUP, {9'd6, 30'd0}, '0, '0);             // miss below orphan L1
    push_item(REQ_MAP, 39'h2000, 56'hAB_CDEF_0123_4000, 10'h155);  // existing tables
    push_item(REQ_LOOKUP, 39'h2000, '0, '0);
    wait_drained();

    // ---- random phases: one register setting and one idle mode each ----
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      rnd   = {$urandom, $urandom};
      lim_v = 64'd4096 + rnd % (64'(VA_TOP) - 64'd4095);
      case (phase)
        0: begin base_v = 64'(DIR_BASE);  lim_v = 64'(VA_TOP);    end
        1: begin base_v = '0;             lim_v = 64'd4096;       end
        2: begin base_v = '1;                                     end
        3: begin base_v = 64'(DIR_BASE);  lim_v = 64'(LIMIT_RST); end
        4: begin base_v = {$urandom, $urandom};                   end
        6: begin base_v = 64'(BASE_RST);  lim_v = 64'(VA_TOP);    end
        default: base_v = 64'(DIR_BASE);
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 50; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase
      write_cfg(CFG_TABLE_BASE, base_v[CFG_W-1:0]);
      write_cfg(CFG_VA_LIMIT, lim_v[CFG_W-1:0]);
      n_settings++;

      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        // mostly slots whose tables already exist, so walks reach the leaf
        k    = $urandom_range(7);
        vpn2 = (k == 7) ? 9'd255 : 9'(k);
        if ($urandom_range(3) == 0) vpn2 = 9'($urandom);
        vpn1 = $urandom_range(1) ? 9'd0 : 9'd511;
        if ($urandom_range(3) == 0) vpn1 = 9'($urandom);
        va  = {vpn2, vpn1, 9'($urandom), 12'h000};
        rnd = {$urandom, $urandom};
        pa  = {rnd[55:12], 12'h000};
        if (pick < 40) begin
          push_item(REQ_MAP, va, pa, 10'($urandom));
        end else if (pick < 70) begin
          va = va_pool[$urandom_range(va_pool.size() - 1)];
          if ($urandom_range(1)) va[11:0] = rnd[11:0];
          push_item(REQ_LOOKUP, va, rnd[63:8], 10'($urandom));
        end else if (pick < 85) begin
          push_item(REQ_MAP, va_pool[$urandom_range(va_pool.size() - 1)], pa,
                    10'($urandom));
        end else begin
          // noise: every field fully random; about half are lookups, and the maps are mostly misaligned
          va = VA_W'({$urandom, $urandom});
          push_item(1'($urandom), va, rnd[55:0], 10'($urandom));
        end
      end
      wait_drained();
    end

    // let the pipeline settle; any late or extra beat gets flagged
    repeat (20) @(posedge clk_i);

    $display("covered %0d requests over %0d register settings and four idle/stall mixes",
             n_req, n_settings);
    $display("status mix: ok %0d, range %0d, align %0d, remap %0d, no page %0d, not mapped %0d",
             status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_ALIGN],
             status_seen[ST_REMAP], status_seen[ST_NOPAGE], status_seen[ST_NOTMAP]);
    if (err_cnt == 0 && walk_rsp_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
